>>> hw/rtl/isc_pkg.sv
// ----------------------------------------------------------------------------
// Induced subgraph connectivity package
// Shared widths, item codes, state encoding and the structs that pass
// between the top level and the cell row.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int ACTION_W = 2;
  localparam int NODE_W   = 5;
  localparam int MASK_W   = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_QUERY = 2'd2
  } isc_action_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FLOOD = 1'b1
  } isc_state_t;

  // Commands broadcast from the top level to every cell.
  typedef struct packed {
    logic clr;
    logic add;
    logic load;
    logic flood;
  } isc_ctrl_t;

  // Signals rippled from one cell to the next along the row.
  typedef struct packed {
    logic lower;  // some member sits at a lower node index
    logic grew;   // some lower cell gained a node in this round
  } isc_link_t;

endpackage

>>> hw/rtl/isc_if.sv
// ----------------------------------------------------------------------------
// Induced subgraph connectivity channels
// Valid/ready interfaces for the item channel and the result channel.
// ----------------------------------------------------------------------------
interface isc_in_if;
  import isc_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [NODE_W-1:0]   node_a;
  logic [NODE_W-1:0]   node_b;
  logic [MASK_W-1:0]   subset_mask;

  modport source (output valid, output action, output node_a, output node_b,
                  output subset_mask, input ready);
  modport sink   (input valid, input action, input node_a, input node_b,
                  input subset_mask, output ready);
endinterface

interface isc_out_if;
  logic valid;
  logic ready;
  logic connected;
  logic empty_subset;

  modport source (output valid, output connected, output empty_subset, input ready);
  modport sink   (input valid, input connected, input empty_subset, output ready);
endinterface

>>> hw/rtl/isc_cell.sv
// ----------------------------------------------------------------------------
// Induced subgraph connectivity cell
// Holds one adjacency row, the membership bit and the reached bit of one
// node, and ripples the lowest-member and growth flags to its neighbor.
// ----------------------------------------------------------------------------
module isc_cell #(
  parameter int NODES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  isc_pkg::isc_ctrl_t ctrl,
  input  logic              hit_a,
  input  logic              hit_b,
  input  logic [NODES-1:0]  sel_a,
  input  logic [NODES-1:0]  sel_b,
  input  logic [NODES-1:0]  reach_vec,
  input  logic              mem_in,
  input  isc_pkg::isc_link_t link_in,
  output isc_pkg::isc_link_t link_out,
  output logic              reached,
  output logic              member
);
  import isc_pkg::*;

  logic [NODES-1:0] row_r, row_nxt;
  logic             member_r, member_nxt;
  logic             reached_r, reached_nxt;
  logic             adj_hit;
  logic             gain;

  // The matrix is symmetric, so a neighbor already reached shows up in this
  // cell's own row.
  assign adj_hit = |(row_r & reach_vec);
  assign gain    = member_r & adj_hit & ~reached_r;

  always_comb begin
    row_nxt     = row_r;
    member_nxt  = member_r;
    reached_nxt = reached_r;
    if (ctrl.clr) begin
      row_nxt = '0;
    end else if (ctrl.add) begin
      if (hit_a) begin
        row_nxt = row_nxt | sel_b;
      end
      if (hit_b) begin
        row_nxt = row_nxt | sel_a;
      end
    end
    if (ctrl.load) begin
      member_nxt  = mem_in;
      reached_nxt = mem_in & ~link_in.lower;
    end else if (ctrl.flood) begin
      reached_nxt = reached_r | gain;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      member_r  <= 1'b0;
      reached_r <= 1'b0;
    end else begin
      row_r     <= row_nxt;
      member_r  <= member_nxt;
      reached_r <= reached_nxt;
    end
  end

  assign link_out.lower = link_in.lower | mem_in;
  assign link_out.grew  = link_in.grew | gain;
  assign reached        = reached_r;
  assign member         = member_r;

endmodule

>>> hw/rtl/induced_subgraph_connectivity_core.sv
// Sequencing: clear and add-edge beats are taken only while idle; a query beat
//   loads the subset, then flood rounds run through the cell row, one round per
//   cycle, until a round adds no node; the result is then registered once no unread result is pending.
// Throughput: one query at a time; no new item is taken until its result is registered.
// Reset: synchronous active-low rst_n empties the adjacency matrix and
//   clears the result valid flag; the result value registers are not reset.
// ----------------------------------------------------------------------------
// Induced subgraph connectivity core
// Keeps an undirected graph as a row of cells, one adjacency row per cell,
// and floods a node subset from its lowest member to test connectivity.
// ----------------------------------------------------------------------------
module induced_subgraph_connectivity_core #(
  parameter int NODES = 32
) (
  input  logic clk,
  input  logic rst_n,
  isc_in_if.sink    in_bus,
  isc_out_if.source out_bus
);
  import isc_pkg::*;

  isc_state_t       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_connected_r, out_connected_nxt;
  logic             out_empty_subset_r, out_empty_subset_nxt;
  logic             empty_r, empty_nxt;

  isc_ctrl_t        ctrl;
  isc_link_t        links [NODES+1];
  logic [NODES-1:0] reached_vec;
  logic [NODES-1:0] member_vec;
  logic [NODES-1:0] mask_ext;
  logic [NODES-1:0] sel_a;
  logic [NODES-1:0] sel_b;
  logic             in_fire;
  logic             edge_ok;
  logic             done;

  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;

  // Endpoints beyond the node count make the add-edge beat a no-op.
  assign edge_ok = (32'(in_bus.node_a) < NODES) && (32'(in_bus.node_b) < NODES);
  assign sel_a   = edge_ok ? (NODES'(1) << in_bus.node_a) : '0;
  assign sel_b   = edge_ok ? (NODES'(1) << in_bus.node_b) : '0;

  // Mask bits above the node count name no node and are dropped.
  if (NODES <= MASK_W) begin : g_mask_trunc
    assign mask_ext = in_bus.subset_mask[NODES-1:0];
  end else begin : g_mask_ext
    assign mask_ext = NODES'(in_bus.subset_mask);
  end

  always_comb begin
    ctrl       = '0;
    ctrl.flood = (state_r == ST_FLOOD);
    if (in_fire) begin
      unique case (isc_action_t'(in_bus.action))
        ACT_CLEAR: ctrl.clr  = 1'b1;
        ACT_ADD:   ctrl.add  = 1'b1;
        ACT_QUERY: ctrl.load = 1'b1;
        default:   ctrl      = '0;
      endcase
    end
  end

  assign links[0] = '0;

  for (genvar i = 0; i < NODES; i++) begin : g_cell
    isc_cell #(
      .NODES (NODES)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .hit_a     (sel_a[i]),
      .hit_b     (sel_b[i]),
      .sel_a     (sel_a),
      .sel_b     (sel_b),
      .reach_vec (reached_vec),
      .mem_in    (mask_ext[i]),
      .link_in   (links[i]),
      .link_out  (links[i+1]),
      .reached   (reached_vec[i]),
      .member    (member_vec[i])
    );
  end

  assign done = !links[NODES].grew;

  always_comb begin
    state_nxt            = state_r;
    out_valid_nxt        = out_valid_r && !out_bus.ready;
    out_connected_nxt    = out_connected_r;
    out_empty_subset_nxt = out_empty_subset_r;
    empty_nxt            = empty_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ctrl.load) begin
          empty_nxt = !links[NODES].lower;
          state_nxt = ST_FLOOD;
        end
      end
      ST_FLOOD: begin
        // A finished flood waits here while the previous result is unread.
        if (done && (!out_valid_r || out_bus.ready)) begin
          out_valid_nxt        = 1'b1;
          out_connected_nxt    = (reached_vec == member_vec);
          out_empty_subset_nxt = empty_r;
          state_nxt            = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      empty_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      empty_r     <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_connected_r    <= out_connected_nxt;
    out_empty_subset_r <= out_empty_subset_nxt;
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.connected    = out_connected_r;
  assign out_bus.empty_subset = out_empty_subset_r;

  // Only members of the subset can ever be reached.
  a_reach_in_members: assert property (@(posedge clk) disable iff (!rst_n)
    ((reached_vec & ~member_vec) == '0))
    else $error("reached node outside the queried subset");

  // A flood round never drops a node that was already reached.
  a_reach_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLOOD) |=> (($past(reached_vec) & ~reached_vec) == '0))
    else $error("reached set shrank during flooding");

  // An empty subset always reports connected.
  a_empty_connected: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_subset_r) |-> out_connected_r)
    else $error("empty subset reported as disconnected");

endmodule
